/* design/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, status codes and decode helpers for the MIDI stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int unsigned OUT_LIMIT = 32;    // most stored SysEx bytes ever emitted
    localparam int unsigned CAP_W     = 6;     // capacity, count and length width
    localparam int unsigned IDX_W     = 5;     // SysEx result index width

    localparam logic [7:0] ST_NONE    = 8'h00;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_SONGPOS = 8'hF2;
    localparam logic [7:0] ST_TUNE    = 8'hF6;
    localparam logic [7:0] ST_EOX     = 8'hF7;
    localparam logic [7:0] ST_PITCH   = 8'hE0;

    // channel message types (upper nibble)
    localparam logic [7:0] ST_KEY_UP   = 8'h80;
    localparam logic [7:0] ST_KEY_DOWN = 8'h90;
    localparam logic [7:0] ST_POLY_AT  = 8'hA0;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT  = 8'hD0;

    // system common with one data byte
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SONG_NUM = 8'hF3;

    // real time
    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONT     = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;
    localparam logic [7:0] ST_SENSE    = 8'hFE;
    localparam logic [7:0] ST_SYS_RST  = 8'hFF;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DRAIN_RD,
        S_DRAIN_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the incoming byte
        logic decode;   // commit the decode of the captured byte
        logic emit;     // push one stored SysEx byte to the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_out;     // decode of the captured byte makes one result
        logic drain;       // captured byte is an EOX with stored SysEx bytes
        logic out_free;    // output register can take a result this cycle
        logic drain_last;  // current drain index is the final stored byte
    } t_status;

    // number of data bytes a message type carries (0 for none or undefined)
    function automatic logic [1:0] msg_len(input logic [7:0] t);
        logic [1:0] n;
        unique case (t)
            ST_KEY_UP, ST_KEY_DOWN, ST_POLY_AT, ST_CTRL, ST_PITCH, ST_SONGPOS: n = 2'd2;
            ST_PROG, ST_CHAN_AT, ST_MTC, ST_SONG_NUM:                          n = 2'd1;
            default:                                                           n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_real_time(input logic [7:0] b);
        return (b == ST_CLOCK) || (b == ST_START) || (b == ST_CONT) ||
               (b == ST_STOP) || (b == ST_SENSE) || (b == ST_SYS_RST);
    endfunction

endpackage

`default_nettype wire

/* design/msd_ctrl.sv */
// ----------------------------------------------------------------------------
// msd_ctrl
// Sequencer: takes one byte, commits its decode, and walks the SysEx store
// out through the output register on EOX.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_ctrl import msd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                // hold off while a single result cannot yet be placed
                if (!i_status.has_out || i_status.out_free) begin
                    o_cmd.decode = 1'b1;
                    n_state      = i_status.drain ? S_DRAIN_RD : S_IDLE;
                end
            end
            S_DRAIN_RD: begin
                // store read data lands in its register this cycle
                n_state = S_DRAIN_EMIT;
            end
            S_DRAIN_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.drain_last ? S_IDLE : S_DRAIN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/msd_datapath.sv */
// ----------------------------------------------------------------------------
// msd_datapath
// Message state, running-status decode, SysEx store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_datapath import msd_pkg::*; #(
    parameter int unsigned SYSEX_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic [7:0]       i_byte_in,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_msg_type,
    output logic [3:0]            o_channel,
    output logic [6:0]            o_data_first,
    output logic [6:0]            o_data_second,
    output logic [13:0]           o_value_wide,
    output logic [CAP_W-1:0]      o_sysex_length,
    output logic [IDX_W-1:0]      o_sysex_index,
    output logic [6:0]            o_sysex_byte,
    output logic                  o_is_last
);

    localparam int unsigned STORE_N = (SYSEX_DEPTH < OUT_LIMIT) ? SYSEX_DEPTH : OUT_LIMIT;
    localparam int unsigned AW      = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam logic [CAP_W-1:0] STORE_N_W = CAP_W'(STORE_N);

    // message state
    logic [CAP_W-1:0] r_cap;
    logic [7:0]       r_type,  n_type;
    logic [3:0]       r_chan,  n_chan;
    logic [CAP_W-1:0] r_rem,   n_rem;
    logic [6:0]       r_held,  n_held;

    logic [7:0]       r_byte;

    // drain bookkeeping
    logic [CAP_W-1:0] r_len;
    logic [IDX_W-1:0] r_idx;

    // SysEx store with registered read port
    logic [6:0]       r_store [STORE_N];
    logic [6:0]       r_rd;

    // output register
    logic             r_out_valid;
    logic [7:0]       r_msg_type;
    logic [3:0]       r_channel;
    logic [6:0]       r_data_first;
    logic [6:0]       r_data_second;
    logic [13:0]      r_value_wide;
    logic [CAP_W-1:0] r_sysex_length;
    logic [IDX_W-1:0] r_sysex_index;
    logic [6:0]       r_sysex_byte;
    logic             r_is_last;

    // decode results
    logic             has_out;
    logic             drain;
    logic             wr_en;
    logic [7:0]       res_type;
    logic [3:0]       res_chan;
    logic [6:0]       res_d1;
    logic [6:0]       res_d2;
    logic [13:0]      res_wide;
    logic [CAP_W-1:0] limit;
    logic             out_free;
    logic             drain_last;

    assign limit      = (r_cap < STORE_N_W) ? r_cap : STORE_N_W;
    assign out_free   = !r_out_valid || i_out_ready;
    assign drain_last = ({1'b0, r_idx} + CAP_W'(1)) == r_len;

    always_comb begin
        logic [7:0] nt;
        logic [3:0] nc;
        logic [1:0] len;
        logic [1:0] eff;
        n_type   = r_type;
        n_chan   = r_chan;
        n_rem    = r_rem;
        n_held   = r_held;
        has_out  = 1'b0;
        drain    = 1'b0;
        wr_en    = 1'b0;
        res_type = ST_NONE;
        res_chan = '0;
        res_d1   = '0;
        res_d2   = '0;
        res_wide = '0;
        nt       = (r_byte >= ST_SYSEX) ? r_byte : {r_byte[7:4], 4'h0};
        nc       = (r_byte >= ST_SYSEX) ? 4'h0 : r_byte[3:0];
        len      = msg_len(r_type);
        eff      = ((r_rem == '0) || (r_rem > CAP_W'(2))) ? len : r_rem[1:0];
        if (r_byte[7]) begin
            priority if (is_real_time(r_byte)) begin
                has_out  = 1'b1;
                res_type = r_byte;
            end else if (r_byte == ST_SYSEX) begin
                n_type = ST_SYSEX;
                n_chan = '0;
                n_rem  = '0;
            end else if (r_byte == ST_EOX) begin
                // EOX outside SysEx is dropped
                if (r_type == ST_SYSEX) begin
                    n_type = ST_NONE;
                    n_chan = '0;
                    n_rem  = '0;
                    if (r_rem == '0) begin
                        has_out  = 1'b1;
                        res_type = ST_SYSEX;
                    end else begin
                        drain = 1'b1;
                    end
                end
            end else begin
                n_type = nt;
                n_chan = nc;
                n_rem  = {{(CAP_W-2){1'b0}}, msg_len(nt)};
                if (nt == ST_TUNE) begin
                    has_out  = 1'b1;
                    res_type = nt;
                    res_chan = nc;
                end
            end
        end else if (r_type == ST_SYSEX) begin
            if (r_rem < limit) begin
                wr_en = 1'b1;
                n_rem = r_rem + CAP_W'(1);
            end
        end else if (len != 2'd0) begin
            if (eff == 2'd2) begin
                n_held = r_byte[6:0];
                n_rem  = CAP_W'(1);
            end else begin
                n_rem    = '0;
                has_out  = 1'b1;
                res_type = r_type;
                res_chan = r_chan;
                if (len == 2'd1) begin
                    res_d1 = r_byte[6:0];
                end else begin
                    res_d1 = r_held;
                    res_d2 = r_byte[6:0];
                    if ((r_type == ST_PITCH) || (r_type == ST_SONGPOS)) begin
                        res_wide = {r_byte[6:0], r_held};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_type <= ST_NONE;
            r_chan <= '0;
            r_rem  <= '0;
            r_held <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.decode) begin
                r_type <= n_type;
                r_chan <= n_chan;
                r_rem  <= n_rem;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_byte_in;
        end
        if (i_cmd.decode && drain) begin
            r_len <= r_rem;
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && wr_en) begin
            r_store[r_rem[AW-1:0]] <= r_byte[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_store[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.decode && has_out) || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && has_out) begin
            r_msg_type     <= res_type;
            r_channel      <= res_chan;
            r_data_first   <= res_d1;
            r_data_second  <= res_d2;
            r_value_wide   <= res_wide;
            r_sysex_length <= '0;
            r_sysex_index  <= '0;
            r_sysex_byte   <= '0;
            r_is_last      <= 1'b1;
        end else if (i_cmd.emit) begin
            r_msg_type     <= ST_SYSEX;
            r_channel      <= '0;
            r_data_first   <= '0;
            r_data_second  <= '0;
            r_value_wide   <= '0;
            r_sysex_length <= r_len;
            r_sysex_index  <= r_idx;
            r_sysex_byte   <= r_rd;
            r_is_last      <= drain_last;
        end
    end

    assign o_status.has_out    = has_out;
    assign o_status.drain      = drain;
    assign o_status.out_free   = out_free;
    assign o_status.drain_last = drain_last;

    assign o_out_valid    = r_out_valid;
    assign o_msg_type     = r_msg_type;
    assign o_channel      = r_channel;
    assign o_data_first   = r_data_first;
    assign o_data_second  = r_data_second;
    assign o_value_wide   = r_value_wide;
    assign o_sysex_length = r_sysex_length;
    assign o_sysex_index  = r_sysex_index;
    assign o_sysex_byte   = r_sysex_byte;
    assign o_is_last      = r_is_last;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((i_cmd.decode && has_out) || i_cmd.emit) && r_out_valid) |-> i_out_ready)
        else $error("result loaded over a pending one");

    // drain stays inside the stored length
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> ({1'b0, r_idx} < r_len))
        else $error("SysEx drain index past stored length");

    // a drain always starts with at least one stored byte
    a_drain_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decode && drain) |=> (r_len != '0) && (r_idx == '0))
        else $error("SysEx drain started empty");

    // the SysEx count never runs past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_type == ST_SYSEX) |-> (r_rem <= STORE_N_W))
        else $error("SysEx count beyond store depth");

endmodule

`default_nettype wire

/* design/midi_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// midi_stream_decoder_unit
// MIDI 1.0 byte-stream decoder with running status and SysEx capture.
// ----------------------------------------------------------------------------
// Each byte is captured on accept and decoded in the following state; a
// decode that makes a result waits while an earlier result is
// still untaken, and no new byte is accepted until that decode is done.
// An EOX that closes a SysEx with N stored bytes emits N results, each read
// through the store's single registered read port and then emitted, and takes no
// new byte until the last one is in the output register. The store is not
// cleared at reset and needs no start-up pass.
`default_nettype none

module midi_stream_decoder_unit import msd_pkg::*; #(
    parameter int unsigned SYSEX_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_byte_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_msg_type,
    output logic [3:0]            o_channel,
    output logic [6:0]            o_data_first,
    output logic [6:0]            o_data_second,
    output logic [13:0]           o_value_wide,
    output logic [CAP_W-1:0]      o_sysex_length,
    output logic [IDX_W-1:0]      o_sysex_index,
    output logic [6:0]            o_sysex_byte,
    output logic                  o_is_last
);

    t_cmd    cmd;
    t_status status;

    msd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    msd_datapath #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_byte_in      (i_byte_in),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_msg_type     (o_msg_type),
        .o_channel      (o_channel),
        .o_data_first   (o_data_first),
        .o_data_second  (o_data_second),
        .o_value_wide   (o_value_wide),
        .o_sysex_length (o_sysex_length),
        .o_sysex_index  (o_sysex_index),
        .o_sysex_byte   (o_sysex_byte),
        .o_is_last      (o_is_last)
    );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI stream decoder. A directed table covers
// reset behavior, field extremes and the corner cases of running status and
// SysEx. Random, mostly well-formed message streams follow under several
// SysEx capacity settings. Every output transaction is compared with a
// behavioral decoder kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top import msd_pkg::*; ();

    localparam int DEPTH            = 32;
    localparam int RAND_PHASE_BYTES = 18;
    localparam int N_PHASES         = 6;
    localparam int LONG_SYSEX       = 34;

    // undefined system codes
    localparam logic [7:0] UNDEF_F4 = 8'hF4;
    localparam logic [7:0] UNDEF_F5 = 8'hF5;
    localparam logic [7:0] UNDEF_F9 = 8'hF9;
    localparam logic [7:0] UNDEF_FD = 8'hFD;

    localparam logic [7:0] RT_CODES [6] = '{ST_CLOCK, ST_START, ST_CONT,
                                            ST_STOP, ST_SENSE, ST_SYS_RST};
    localparam logic [7:0] UNDEF_CODES [4] = '{UNDEF_F4, UNDEF_F5, UNDEF_F9, UNDEF_FD};
    localparam logic [7:0] CHAN_TYPES [7] = '{ST_KEY_UP, ST_KEY_DOWN, ST_POLY_AT, ST_CTRL,
                                              ST_PROG, ST_CHAN_AT, ST_PITCH};
    localparam logic [7:0] SYS_COMMON [4] = '{ST_MTC, ST_SONGPOS, ST_SONG_NUM, ST_TUNE};
    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{6'd32, 6'd0, 6'd1,
                                                           6'd5, 6'd63, 6'd20};

    typedef struct packed {
        logic [7:0]       msg_type;
        logic [3:0]       channel;
        logic [6:0]       data_first;
        logic [6:0]       data_second;
        logic [13:0]      value_wide;
        logic [CAP_W-1:0] sysex_length;
        logic [IDX_W-1:0] sysex_index;
        logic [6:0]       sysex_byte;
        logic             is_last;
    } t_midi_msg;

    // typed rows carry a single known result: msg_type set, is_last set, rest zero
    typedef struct packed {
        logic [7:0] stim;
        logic       typed;
        logic [7:0] want_type;
    } t_stim_row;

    localparam t_stim_row DIR_TABLE [33] = '{
        '{8'h00,                1'b0, ST_NONE},     // data before any status
        '{ST_CLOCK,             1'b1, ST_CLOCK},
        '{ST_SYS_RST,           1'b1, ST_SYS_RST},
        '{ST_KEY_DOWN | 8'h0F,  1'b0, ST_NONE},
        '{8'h00,                1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},     // running status
        '{ST_SENSE,             1'b1, ST_SENSE},    // real time between data bytes
        '{8'h00,                1'b0, ST_NONE},
        '{ST_PITCH,             1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},     // full-scale bend
        '{ST_PROG | 8'h03,      1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},
        '{ST_SONGPOS,           1'b0, ST_NONE},
        '{8'h00,                1'b0, ST_NONE},
        '{8'h00,                1'b0, ST_NONE},
        '{ST_TUNE,              1'b1, ST_TUNE},
        '{8'h05,                1'b0, ST_NONE},     // ignored after tune request
        '{ST_EOX,               1'b0, ST_NONE},     // EOX outside SysEx
        '{ST_SYSEX,             1'b0, ST_NONE},
        '{ST_EOX,               1'b1, ST_SYSEX},    // empty SysEx
        '{ST_SYSEX,             1'b0, ST_NONE},
        '{8'h55,                1'b0, ST_NONE},
        '{8'h2A,                1'b0, ST_NONE},
        '{ST_EOX,               1'b0, ST_NONE},
        '{ST_SYSEX,             1'b0, ST_NONE},
        '{8'h11,                1'b0, ST_NONE},
        '{ST_CTRL | 8'h02,      1'b0, ST_NONE},     // closes SysEx silently
        '{8'h40,                1'b0, ST_NONE},
        '{8'h7F,                1'b0, ST_NONE},
        '{UNDEF_F4,             1'b0, ST_NONE},
        '{8'h12,                1'b0, ST_NONE}      // ignored after undefined status
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CAP_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic [7:0]       i_byte_in   = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [7:0]       o_msg_type;
    logic [3:0]       o_channel;
    logic [6:0]       o_data_first;
    logic [6:0]       o_data_second;
    logic [13:0]      o_value_wide;
    logic [CAP_W-1:0] o_sysex_length;
    logic [IDX_W-1:0] o_sysex_index;
    logic [6:0]       o_sysex_byte;
    logic             o_is_last;

    // behavioral decoder state
    logic [CAP_W-1:0] m_cap;
    logic [7:0]       m_type;
    logic [3:0]       m_chan;
    int               m_rem;
    logic [6:0]       m_held;
    logic [6:0]       m_store [DEPTH];

    t_midi_msg        exp_q [$];
    t_midi_msg        pred_q [$];
    t_midi_msg        got;
    t_midi_msg        want;
    int               n_sent    = 0;
    int               n_checked = 0;
    int               n_errors  = 0;

    midi_stream_decoder_unit #(
        .SYSEX_DEPTH (DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_msg_type     (o_msg_type),
        .o_channel      (o_channel),
        .o_data_first   (o_data_first),
        .o_data_second  (o_data_second),
        .o_value_wide   (o_value_wide),
        .o_sysex_length (o_sysex_length),
        .o_sysex_index  (o_sysex_index),
        .o_sysex_byte   (o_sysex_byte),
        .o_is_last      (o_is_last)
    );

    always #5 i_clk = ~i_clk;

    // mostly short idle gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) begin
            return int'($urandom_range(0, 2));
        end
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic tb_real_time(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (RT_CODES[k] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic int payload_len(input logic [7:0] t);
        int n;
        unique case (t)
            ST_KEY_UP, ST_KEY_DOWN, ST_POLY_AT, ST_CTRL, ST_PITCH, ST_SONGPOS: n = 2;
            ST_PROG, ST_CHAN_AT, ST_MTC, ST_SONG_NUM:                          n = 1;
            ST_TUNE:                                                           n = 0;
            default:                                                           n = -1;
        endcase
        return n;
    endfunction

    function automatic t_midi_msg plain_msg(input logic [7:0] t, input logic [3:0] c,
                                            input logic [6:0] d1, input logic [6:0] d2,
                                            input logic [13:0] w);
        t_midi_msg m;
        m             = '0;
        m.msg_type    = t;
        m.channel     = c;
        m.data_first  = d1;
        m.data_second = d2;
        m.value_wide  = w;
        m.is_last     = 1'b1;
        return m;
    endfunction

    function automatic t_midi_msg sysex_msg(input int len, input int k,
                                            input logic [6:0] sb);
        t_midi_msg m;
        m              = '0;
        m.msg_type     = ST_SYSEX;
        m.sysex_length = CAP_W'(len);
        m.sysex_index  = IDX_W'(k);
        m.sysex_byte   = sb;
        m.is_last      = (k + 1 == len);
        return m;
    endfunction

    function automatic logic [7:0] gen_byte();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) begin
            return {1'b0, 7'($urandom_range(0, 127))};
        end
        if (p < 60) begin
            return CHAN_TYPES[$urandom_range(0, 6)] | {4'h0, 4'($urandom_range(0, 15))};
        end
        if (p < 68) begin
            return SYS_COMMON[$urandom_range(0, 3)];
        end
        if (p < 76) begin
            return RT_CODES[$urandom_range(0, 5)];
        end
        if (p < 86) begin
            return ST_SYSEX;
        end
        if (p < 96) begin
            return ST_EOX;
        end
        return UNDEF_CODES[$urandom_range(0, 3)];
    endfunction

    task automatic model_reset();
        m_cap  = CAP_RESET;
        m_type = ST_NONE;
        m_chan = '0;
        m_rem  = 0;
        m_held = '0;
        for (int k = 0; k < DEPTH; k++) begin
            m_store[k] = '0;
        end
    endtask

    // results that one input byte causes land in pred_q
    task automatic model_step(input logic [7:0] b);
        int          n;
        int          len;
        int          lim;
        logic [13:0] wide;
        pred_q.delete();
        if (b[7]) begin
            if (tb_real_time(b)) begin
                pred_q.push_back(plain_msg(b, '0, '0, '0, '0));
            end else if (b == ST_SYSEX) begin
                m_type = ST_SYSEX;
                m_chan = '0;
                m_rem  = 0;
            end else if (b == ST_EOX) begin
                if (m_type == ST_SYSEX) begin
                    len    = (m_rem > DEPTH) ? DEPTH : m_rem;
                    m_type = ST_NONE;
                    m_chan = '0;
                    m_rem  = 0;
                    if (len == 0) begin
                        pred_q.push_back(plain_msg(ST_SYSEX, '0, '0, '0, '0));
                    end else begin
                        for (int k = 0; k < len; k++) begin
                            pred_q.push_back(sysex_msg(len, k, m_store[k]));
                        end
                    end
                end
            end else begin
                if (b >= ST_SYSEX) begin
                    m_type = b;
                    m_chan = '0;
                end else begin
                    m_type = {b[7:4], 4'h0};
                    m_chan = b[3:0];
                end
                n     = payload_len(m_type);
                m_rem = (n > 0) ? n : 0;
                if (n == 0) begin
                    pred_q.push_back(plain_msg(m_type, m_chan, '0, '0, '0));
                end
            end
        end else if (m_type == ST_SYSEX) begin
            lim = int'(m_cap);
            if (lim > DEPTH) begin
                lim = DEPTH;
            end
            if (m_rem < lim) begin
                m_store[m_rem] = b[6:0];
                m_rem++;
            end
        end else begin
            n = payload_len(m_type);
            if (n > 0) begin
                if ((m_rem == 0) || (m_rem > 2)) begin
                    m_rem = n;
                end
                if (m_rem == 2) begin
                    m_held = b[6:0];
                    m_rem  = 1;
                end else begin
                    m_rem = 0;
                    if (n == 1) begin
                        pred_q.push_back(plain_msg(m_type, m_chan, b[6:0], '0, '0));
                    end else begin
                        wide = '0;
                        if ((m_type == ST_PITCH) || (m_type == ST_SONGPOS)) begin
                            wide = {b[6:0], m_held};
                        end
                        pred_q.push_back(plain_msg(m_type, m_chan, m_held, b[6:0], wide));
                    end
                end
            end
        end
    endtask

    // valid rises at the earliest on the edge after the last transaction
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        i_in_valid <= 1'b0;
    endtask

    task automatic apply(input logic [7:0] b, input logic typed, input logic [7:0] want_type);
        send_byte(b);
        n_sent++;
        model_step(b);
        if (typed) begin
            exp_q.push_back(plain_msg(want_type, '0, '0, '0, '0));
        end else begin
            foreach (pred_q[k]) begin
                exp_q.push_back(pred_q[k]);
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while ((exp_q.size() != 0) || o_out_valid || !o_in_ready);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        m_cap = v;
    endtask

    initial begin : ready_drive
        int gap;
        int hold;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            hold = $urandom_range(1, 4);
            repeat (hold) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_msg_type, o_channel, o_data_first, o_data_second, o_value_wide,
                   o_sysex_length, o_sysex_index, o_sysex_byte, o_is_last};
            n_checked++;
            if (exp_q.size() == 0) begin
                n_errors++;
                $display("%0t ERROR: expected no result, actual %h", $time, got);
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    $display("%0t ERROR: expected %h, actual %h", $time, want, got);
                end
            end
        end
    end

    initial begin : main
        int idx;
        int ph;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < $size(DIR_TABLE); idx++) begin
            apply(DIR_TABLE[idx].stim, DIR_TABLE[idx].typed, DIR_TABLE[idx].want_type);
        end

        // overflow at the reset capacity: the last two data bytes are dropped
        apply(ST_SYSEX, 1'b0, ST_NONE);
        for (idx = 0; idx < LONG_SYSEX; idx++) begin
            apply({1'b0, 7'(idx * 5 + 1)}, 1'b0, ST_NONE);
        end
        apply(ST_EOX, 1'b0, ST_NONE);

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_cap(PHASE_CAPS[ph]);
            for (idx = 0; idx < RAND_PHASE_BYTES; idx++) begin
                apply(gen_byte(), 1'b0, ST_NONE);
            end
        end

        wait_idle();
        $display("Sent %0d bytes: directed corner cases, a full SysEx with overflow,",
                 n_sent);
        $display("and random streams under %0d capacity settings; %0d results checked.",
                 N_PHASES, n_checked);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("%0t ERROR: expected the run to end, actual timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
